// ===== rtl/csse_pkg.sv =====
// shared types and constants of the character-set scan engine
package csse_pkg;

	// field widths
	localparam int CMD_BITS      = 2;
	localparam int BYTE_BITS     = 8;
	localparam int PORT_CUR_BITS = 16;
	localparam int SET_SIZE      = 256;
	localparam int SET_WORD_BITS = 64;
	localparam int SET_WORDS     = 4;
	localparam int MODE_BITS     = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int FOLD_DEPTH    = 256;

	// queue between front and back
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = 2;
	localparam int QCNT_BITS     = 3;

	// input commands
	localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_BEGIN = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_CHAR  = 2'd2;

	// scan modes
	localparam logic [MODE_BITS-1:0] MODE_SPAN       = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_BREAK      = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_BREAK_PAST = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_PAST_NON   = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_FIND_MEM   = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_FIND_NON   = 3'd5;
	localparam logic [MODE_BITS-1:0] MODE_LAST_VALID = MODE_FIND_NON;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SET0   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SET1   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SET2   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SET3   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_ANCHOR = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRONT  = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_CASE   = 3'd7;

	typedef struct packed {
		logic [CMD_BITS-1:0]      command;
		logic [BYTE_BITS-1:0]     byte_value;
		logic [BYTE_BITS-1:0]     fold_value;
		logic [PORT_CUR_BITS-1:0] start_cursor;
		logic                     at_end;
		logic                     last_char;
	} item_t;

	typedef struct packed {
		logic                     matched;
		logic [PORT_CUR_BITS-1:0] new_cursor;
	} result_t;

	// classified operation handed from front to back
	typedef struct packed {
		logic                     is_begin;
		logic                     mem;
		logic                     fold_mem;
		logic [PORT_CUR_BITS-1:0] cursor;
		logic                     at_end;
		logic                     last;
	} scan_op_t;

	// scan options seen by the back end
	typedef struct packed {
		logic [MODE_BITS-1:0] scan_mode;
		logic                 anchor_mode;
		logic                 stay_in_front;
		logic                 case_exact;
	} scan_cfg_t;

endpackage

// ===== rtl/csse_ram.sv =====
// generic single-port-write, single-port-read RAM with registered read
module csse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/csse_front.sv =====
// front end: accepts beats, loads the fold table, classifies subject bytes
module csse_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  csse_pkg::item_t                 item,
	input  logic [csse_pkg::SET_SIZE-1:0]   set_bits,
	input  logic                            queue_full,
	output logic                            push_valid,
	output csse_pkg::scan_op_t              push_op
);

	logic                                  accept;
	logic                                  keep;
	logic                                  s1_valid_s1;
	logic                                  is_begin_s1;
	logic                                  mem_s1;
	logic [csse_pkg::PORT_CUR_BITS-1:0]    cursor_s1;
	logic                                  at_end_s1;
	logic                                  last_s1;
	logic [csse_pkg::BYTE_BITS-1:0]        fold_byte;

	// stage 1 may only move on when the queue has room
	assign item_stall = s1_valid_s1 && queue_full;
	assign accept     = item_valid && !item_stall;
	assign keep       = (item.command == csse_pkg::CMD_BEGIN) ||
	                    (item.command == csse_pkg::CMD_CHAR);

	// fold table, read with the subject byte
	csse_ram #(
		.WIDTH(csse_pkg::BYTE_BITS),
		.DEPTH(csse_pkg::FOLD_DEPTH)
	) u_fold_ram (
		.clk   (clk),
		.we    (accept && (item.command == csse_pkg::CMD_LOAD)),
		.waddr (item.byte_value),
		.wdata (item.fold_value),
		.re    (accept && (item.command == csse_pkg::CMD_CHAR)),
		.raddr (item.byte_value),
		.rdata (fold_byte)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			s1_valid_s1 <= accept && keep;
		end
	end

	// stage 1 payload with the byte's own membership
	always_ff @(posedge clk) begin
		if (accept) begin
			is_begin_s1 <= (item.command == csse_pkg::CMD_BEGIN);
			mem_s1      <= set_bits[item.byte_value];
			cursor_s1   <= item.start_cursor;
			at_end_s1   <= item.at_end;
			last_s1     <= item.last_char;
		end
	end

	// membership of the folded byte joins here
	always_comb begin
		push_valid       = s1_valid_s1;
		push_op.is_begin = is_begin_s1;
		push_op.mem      = mem_s1;
		push_op.fold_mem = set_bits[fold_byte];
		push_op.cursor   = cursor_s1;
		push_op.at_end   = at_end_s1;
		push_op.last     = last_s1;
	end

endmodule

// ===== rtl/csse_queue.sv =====
// short queue of classified operations between front and back
module csse_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  csse_pkg::scan_op_t   push_op,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output csse_pkg::scan_op_t   head
);

	csse_pkg::scan_op_t                  entry_q [csse_pkg::QUEUE_DEPTH];
	logic [csse_pkg::QPTR_BITS-1:0]      wr_ptr_q;
	logic [csse_pkg::QPTR_BITS-1:0]      rd_ptr_q;
	logic [csse_pkg::QCNT_BITS-1:0]      count_q;
	logic                                push;
	logic                                do_pop;

	assign full   = (count_q == csse_pkg::QCNT_BITS'(csse_pkg::QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign push   = push_valid && !full;
	assign do_pop = pop && !empty;
	assign head   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= csse_pkg::QCNT_BITS'(csse_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

	a_count_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not follow a pop");
`endif

endmodule

// ===== rtl/csse_back.sv =====
// back end: scan state per subject byte and the result register
module csse_back #(
	parameter int CURSOR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csse_pkg::scan_cfg_t  cfg,
	input  logic                 queue_empty,
	input  csse_pkg::scan_op_t   head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output csse_pkg::result_t    result
);

	logic                         active_q;
	logic                         first_q;
	logic [CURSOR_BITS-1:0]       pos_q;
	logic [CURSOR_BITS-1:0]       start_q;
	logic                         res_valid_q;
	csse_pkg::result_t            res_q;

	logic                         active_n;
	logic                         first_n;
	logic [CURSOR_BITS-1:0]       pos_n;
	logic [CURSOR_BITS-1:0]       start_n;
	logic                         emit;
	logic                         ok;
	logic [CURSOR_BITS-1:0]       cur;
	logic [CURSOR_BITS-1:0]       p1;
	logic                         hit;

	// take the next operation when the result register is free
	assign pop = !queue_empty && (!res_valid_q || !result_stall);
	assign p1  = pos_q + 1'b1;

	// scan decision for the head operation
	always_comb begin
		active_n = active_q;
		first_n  = first_q;
		pos_n    = pos_q;
		start_n  = start_q;
		emit     = 1'b0;
		ok       = 1'b0;
		cur      = pos_q;
		hit      = 1'b0;
		if (head.is_begin) begin
			start_n  = CURSOR_BITS'(head.cursor);
			pos_n    = CURSOR_BITS'(head.cursor);
			active_n = 1'b1;
			first_n  = 1'b1;
			if (head.at_end || (cfg.scan_mode > csse_pkg::MODE_LAST_VALID)) begin
				emit = 1'b1;
			end
		end else if (active_q) begin
			unique case (cfg.scan_mode)
				csse_pkg::MODE_SPAN: begin
					if (!head.mem) begin
						emit = 1'b1;
						ok   = !first_q;
						cur  = pos_q;
					end else if (head.last) begin
						emit = 1'b1;
						ok   = 1'b1;
						cur  = p1;
					end
				end
				csse_pkg::MODE_BREAK: begin
					if (head.mem || head.last) begin
						emit = 1'b1;
						ok   = head.mem;
						cur  = pos_q;
					end
				end
				csse_pkg::MODE_BREAK_PAST: begin
					if (head.mem || head.last) begin
						emit = 1'b1;
						ok   = head.mem;
						cur  = p1;
					end
				end
				csse_pkg::MODE_PAST_NON: begin
					if (!head.mem || head.last) begin
						emit = 1'b1;
						ok   = !head.mem;
						cur  = p1;
					end
				end
				csse_pkg::MODE_FIND_MEM, csse_pkg::MODE_FIND_NON: begin
					if (cfg.scan_mode == csse_pkg::MODE_FIND_MEM) begin
						hit = head.mem || (!cfg.case_exact && head.fold_mem);
					end else begin
						hit = !head.mem && (cfg.case_exact || !head.fold_mem);
					end
					if (hit || cfg.anchor_mode || head.last) begin
						emit = 1'b1;
						ok   = hit;
						cur  = cfg.stay_in_front ? pos_q : p1;
					end
				end
				default: begin
					emit = 1'b1;
				end
			endcase
			if (!emit) begin
				pos_n   = p1;
				first_n = 1'b0;
			end
		end
		if (emit) begin
			active_n = 1'b0;
			first_n  = 1'b0;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			first_q  <= 1'b0;
			pos_q    <= '0;
			start_q  <= '0;
		end else if (pop) begin
			active_q <= active_n;
			first_q  <= first_n;
			pos_q    <= pos_n;
			start_q  <= start_n;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !result_stall) begin
			res_valid_q <= pop && emit;
		end
	end

	// result register payload; a failed scan reports the start cursor
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q.matched    <= ok;
			res_q.new_cursor <= csse_pkg::PORT_CUR_BITS'(ok ? cur : start_n);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	a_first_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		first_q |-> active_q)
		else $error("first byte pending outside a scan");

	a_verdict_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (!active_q && !first_q))
		else $error("scan still active after its verdict");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && result_stall) |=> (res_valid_q && $stable(res_q)))
		else $error("stalled verdict beat changed");
`endif

endmodule

// ===== rtl/char_set_scan_engine_top.sv =====
// top level of the character-set scan engine: configuration registers and wiring
//
// Takes one beat per cycle while item_stall is low (fold load, scan begin or
// subject byte) and gives at most one verdict per scan: matched with the new
// cursor, or not matched with the start cursor. The sustained rate is one beat
// per clock while nothing stalls, set by the single read port of the fold RAM and
// the two set lookups (own and folded byte) each byte gets in the front end. A
// verdict passes the front stage register (fold RAM read), the four-entry queue
// and the back end's result register. The queue lets the front keep taking beats
// while the result side stalls, until it fills. Cursors wrap mod 2^CURSOR_BITS.
// The fold table has no reset; read only entries that were loaded.
module char_set_scan_engine_top #(
	parameter int CURSOR_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  csse_pkg::item_t                       item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output csse_pkg::result_t                     result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [csse_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [csse_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	logic [csse_pkg::SET_WORDS-1:0][csse_pkg::SET_WORD_BITS-1:0] set_q;
	csse_pkg::scan_cfg_t    scan_cfg_q;
	logic                   push_valid;
	csse_pkg::scan_op_t     push_op;
	logic                   queue_full;
	logic                   queue_empty;
	logic                   pop;
	csse_pkg::scan_op_t     head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q                    <= '0;
			scan_cfg_q.scan_mode     <= csse_pkg::MODE_SPAN;
			scan_cfg_q.anchor_mode   <= 1'b0;
			scan_cfg_q.stay_in_front <= 1'b0;
			scan_cfg_q.case_exact    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				csse_pkg::REG_SET0:   set_q[0] <= cfg_data;
				csse_pkg::REG_SET1:   set_q[1] <= cfg_data;
				csse_pkg::REG_SET2:   set_q[2] <= cfg_data;
				csse_pkg::REG_SET3:   set_q[3] <= cfg_data;
				csse_pkg::REG_MODE:   scan_cfg_q.scan_mode <=
				                          cfg_data[csse_pkg::MODE_BITS-1:0];
				csse_pkg::REG_ANCHOR: scan_cfg_q.anchor_mode   <= cfg_data[0];
				csse_pkg::REG_FRONT:  scan_cfg_q.stay_in_front <= cfg_data[0];
				csse_pkg::REG_CASE:   scan_cfg_q.case_exact    <= cfg_data[0];
			endcase
		end
	end

	// accept and classify
	csse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.set_bits   (set_q),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_op    (push_op)
	);

	// decoupling queue
	csse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.full       (queue_full),
		.pop        (pop),
		.empty      (queue_empty),
		.head       (head)
	);

	// scan and result
	csse_back #(
		.CURSOR_BITS(CURSOR_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (scan_cfg_q),
		.queue_empty  (queue_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== tb/char_set_scan_engine_top_test.sv =====
// self-checking testbench for the character-set scan engine top level
module char_set_scan_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 5;
	localparam int SETTLE       = 12;
	localparam int HOLD_CYCLES  = 80;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASES       = 12;
	localparam int CHUNK_ITEMS  = 30;

	// codes the block does not use
	localparam logic [csse_pkg::CMD_BITS-1:0]  CMD_SPARE     = 2'd3;
	localparam logic [csse_pkg::MODE_BITS-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [csse_pkg::MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               item_valid = 1'b0;
	logic                               item_stall;
	csse_pkg::item_t                    item = '0;
	logic                               result_valid;
	logic                               result_stall = 1'b0;
	csse_pkg::result_t                  result;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [csse_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [csse_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	char_set_scan_engine_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// beats waiting to be offered, verdicts waiting to come out
	csse_pkg::item_t   beats_pending [$];
	csse_pkg::result_t verdicts_due [$];

	// shadow of the configuration registers
	logic [csse_pkg::SET_WORD_BITS-1:0] set_copy [csse_pkg::SET_WORDS];
	logic [csse_pkg::MODE_BITS-1:0]     mode_copy = csse_pkg::MODE_SPAN;
	logic                               anchor_copy = 1'b0;
	logic                               front_copy = 1'b0;
	logic                               exact_copy = 1'b1;

	// shadow of the scan state
	logic [csse_pkg::BYTE_BITS-1:0]     fold_copy [csse_pkg::FOLD_DEPTH];
	logic [csse_pkg::PORT_CUR_BITS-1:0] scan_pos = '0;
	logic [csse_pkg::PORT_CUR_BITS-1:0] scan_start = '0;
	logic                               scanning = 1'b0;
	logic                               first_pending = 1'b0;

	// fold entries already queued for loading, so no unwritten entry is ever read
	bit                                 fold_queued [csse_pkg::FOLD_DEPTH];
	logic [csse_pkg::BYTE_BITS-1:0]     fold_addrs [$];

	// run control and counters
	bit calm = 1'b0;
	int burst_ask = 0;
	int burst_seen = 0;
	int hold_left = 0;
	int quiet = 0;
	int errors = 0;
	int beats_taken = 0;
	int verdicts_seen = 0;
	int regs_written = 0;
	int settings_done = 0;

	initial begin
		foreach (set_copy[i]) set_copy[i] = '0;
		forever #HALF_PERIOD clk = ~clk;
	end

	task automatic flag_error(input string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	function automatic logic in_set(input logic [csse_pkg::BYTE_BITS-1:0] c);
		return set_copy[c[7:6]][c[5:0]];
	endfunction

	// work out the verdict that one accepted beat causes, if any
	task automatic predict_beat(input csse_pkg::item_t bt);
		logic [csse_pkg::BYTE_BITS-1:0]     b;
		logic [csse_pkg::PORT_CUR_BITS-1:0] p;
		logic [csse_pkg::PORT_CUR_BITS-1:0] p1;
		logic [csse_pkg::PORT_CUR_BITS-1:0] cur;
		logic                               mem;
		logic                               fmem;
		logic                               hit;
		logic                               done;
		logic                               ok;
		csse_pkg::result_t                  v;
		b = bt.byte_value;
		p = scan_pos;
		p1 = scan_pos + 1'b1;
		cur = '0;
		done = 1'b0;
		ok = 1'b0;
		case (bt.command)
			csse_pkg::CMD_LOAD: begin
				fold_copy[b] = bt.fold_value;
			end
			csse_pkg::CMD_BEGIN: begin
				scan_start = bt.start_cursor;
				scan_pos = bt.start_cursor;
				scanning = 1'b1;
				first_pending = 1'b1;
				if (bt.at_end || mode_copy > csse_pkg::MODE_LAST_VALID) done = 1'b1;
			end
			csse_pkg::CMD_CHAR: begin
				if (scanning) begin
					mem = in_set(b);
					fmem = in_set(fold_copy[b]);
					case (mode_copy)
						csse_pkg::MODE_SPAN: begin
							if (first_pending && !mem) begin
								done = 1'b1;
							end else if (!mem) begin
								done = 1'b1; ok = 1'b1; cur = p;
							end else if (bt.last_char) begin
								done = 1'b1; ok = 1'b1; cur = p1;
							end
						end
						csse_pkg::MODE_BREAK: begin
							if (mem) begin
								done = 1'b1; ok = 1'b1; cur = p;
							end else if (bt.last_char) begin
								done = 1'b1;
							end
						end
						csse_pkg::MODE_BREAK_PAST: begin
							if (mem) begin
								done = 1'b1; ok = 1'b1; cur = p1;
							end else if (bt.last_char) begin
								done = 1'b1;
							end
						end
						csse_pkg::MODE_PAST_NON: begin
							if (!mem) begin
								done = 1'b1; ok = 1'b1; cur = p1;
							end else if (bt.last_char) begin
								done = 1'b1;
							end
						end
						csse_pkg::MODE_FIND_MEM, csse_pkg::MODE_FIND_NON: begin
							if (mode_copy == csse_pkg::MODE_FIND_MEM)
								hit = mem || (!exact_copy && fmem);
							else
								hit = !mem && (exact_copy || !fmem);
							if (hit) begin
								done = 1'b1; ok = 1'b1; cur = front_copy ? p : p1;
							end else if (anchor_copy || bt.last_char) begin
								done = 1'b1;
							end
						end
						default: begin
							done = 1'b1;
						end
					endcase
					if (!done) begin
						scan_pos = p1;
						first_pending = 1'b0;
					end
				end
			end
			default: ;
		endcase
		if (done) begin
			v.matched = ok;
			v.new_cursor = ok ? cur : scan_start;
			verdicts_due.push_back(v);
			scanning = 1'b0;
			first_pending = 1'b0;
		end
	endtask

	// input driver: offers queued beats, predicts each accepted one
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				predict_beat(item);
				beats_taken++;
			end
			if (!item_valid || !item_stall) begin
				if (beats_pending.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
					item <= beats_pending.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (burst_ask != burst_seen) begin
			burst_seen <= burst_ask;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor: checks each verdict beat against the oldest prediction
	always @(posedge clk) begin
		csse_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				verdicts_seen++;
				if (verdicts_due.size() == 0) begin
					flag_error($sformatf("verdict %0b/%h with none pending",
						result.matched, result.new_cursor));
				end else begin
					want = verdicts_due.pop_front();
					if (result.matched !== want.matched)
						flag_error($sformatf("matched %b, want %b",
							result.matched, want.matched));
					if (result.new_cursor !== want.new_cursor)
						flag_error($sformatf("new_cursor %h, want %h",
							result.new_cursor, want.new_cursor));
				end
			end
			result_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < 33);
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready) || !arst_n) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet);
			$display("status: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// one register write; cfg_valid stays high for a following write
	task automatic write_reg(input logic [csse_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [csse_pkg::CFG_DATA_BITS-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		regs_written++;
		case (idx)
			csse_pkg::REG_SET0:   set_copy[0] = d;
			csse_pkg::REG_SET1:   set_copy[1] = d;
			csse_pkg::REG_SET2:   set_copy[2] = d;
			csse_pkg::REG_SET3:   set_copy[3] = d;
			csse_pkg::REG_MODE:   mode_copy = d[csse_pkg::MODE_BITS-1:0];
			csse_pkg::REG_ANCHOR: anchor_copy = d[0];
			csse_pkg::REG_FRONT:  front_copy = d[0];
			csse_pkg::REG_CASE:   exact_copy = d[0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [csse_pkg::SET_WORD_BITS-1:0] s0, s1, s2, s3,
			input logic [csse_pkg::MODE_BITS-1:0] md, input logic an, fr, ex);
		@(posedge clk);
		write_reg(csse_pkg::REG_SET0, s0);
		write_reg(csse_pkg::REG_SET1, s1);
		write_reg(csse_pkg::REG_SET2, s2);
		write_reg(csse_pkg::REG_SET3, s3);
		write_reg(csse_pkg::REG_MODE, csse_pkg::CFG_DATA_BITS'(md));
		write_reg(csse_pkg::REG_ANCHOR, csse_pkg::CFG_DATA_BITS'(an));
		write_reg(csse_pkg::REG_FRONT, csse_pkg::CFG_DATA_BITS'(fr));
		write_reg(csse_pkg::REG_CASE, csse_pkg::CFG_DATA_BITS'(ex));
		cfg_valid <= 1'b0;
		settings_done++;
		@(negedge clk);
	endtask

	// beat builders; every non-load beat carries a loaded byte
	function automatic logic [csse_pkg::BYTE_BITS-1:0] any_loaded();
		return fold_addrs[$urandom_range(fold_addrs.size() - 1)];
	endfunction

	function automatic csse_pkg::item_t fresh_beat(input logic [csse_pkg::CMD_BITS-1:0] cmd);
		csse_pkg::item_t bt;
		bt = csse_pkg::item_t'($bits(csse_pkg::item_t)'({$urandom, $urandom}));
		bt.command = cmd;
		bt.byte_value = any_loaded();
		return bt;
	endfunction

	task automatic queue_load(input logic [csse_pkg::BYTE_BITS-1:0] a,
			input logic [csse_pkg::BYTE_BITS-1:0] f);
		csse_pkg::item_t bt;
		bt = csse_pkg::item_t'($bits(csse_pkg::item_t)'({$urandom, $urandom}));
		bt.command = csse_pkg::CMD_LOAD;
		bt.byte_value = a;
		bt.fold_value = f;
		beats_pending.push_back(bt);
		if (!fold_queued[a]) begin
			fold_queued[a] = 1'b1;
			fold_addrs.push_back(a);
		end
	endtask

	task automatic queue_begin(input logic [csse_pkg::PORT_CUR_BITS-1:0] c, input logic e);
		csse_pkg::item_t bt;
		bt = fresh_beat(csse_pkg::CMD_BEGIN);
		bt.start_cursor = c;
		bt.at_end = e;
		beats_pending.push_back(bt);
	endtask

	task automatic queue_char(input logic [csse_pkg::BYTE_BITS-1:0] b, input logic l);
		csse_pkg::item_t bt;
		bt = fresh_beat(csse_pkg::CMD_CHAR);
		bt.byte_value = b;
		bt.last_char = l;
		beats_pending.push_back(bt);
	endtask

	// loaded byte that is a member with the given percent chance
	function automatic logic [csse_pkg::BYTE_BITS-1:0] pick_byte(input int bias);
		logic [csse_pkg::BYTE_BITS-1:0] c;
		logic                           want;
		want = $urandom_range(99) < bias;
		c = any_loaded();
		for (int t = 0; t < 24 && in_set(c) != want; t++)
			c = any_loaded();
		return c;
	endfunction

	// mostly well-formed scans with random content, some noise and cut-off scans
	task automatic queue_scan_traffic(input int quota);
		int n;
		int roll;
		int len;
		int bias;
		logic [csse_pkg::PORT_CUR_BITS-1:0] c;
		n = 0;
		while (n < quota) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				queue_load(csse_pkg::BYTE_BITS'($urandom), csse_pkg::BYTE_BITS'($urandom));
				n++;
			end else if (roll < 11) begin
				case ($urandom_range(2))
					0: beats_pending.push_back(fresh_beat(CMD_SPARE));
					1: queue_char(any_loaded(), 1'($urandom));
					default: queue_begin(csse_pkg::PORT_CUR_BITS'($urandom), 1'b1);
				endcase
				n++;
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
				case ($urandom_range(2))
					0: bias = 10;
					1: bias = 50;
					default: bias = 90;
				endcase
				c = ($urandom_range(3) == 0) ? 16'hFFF0 + 16'($urandom_range(15))
					: csse_pkg::PORT_CUR_BITS'($urandom);
				queue_begin(c, $urandom_range(24) == 0);
				for (int i = 0; i < len; i++)
					queue_char(pick_byte(bias), i == len - 1 && $urandom_range(19) != 0);
				n += len + 1;
			end
		end
	endtask

	// wait for every beat and verdict, then for the pipeline to empty
	task automatic drain(input int extra);
		do @(negedge clk);
		while (beats_pending.size() != 0 || item_valid || verdicts_due.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	function automatic logic [csse_pkg::SET_WORD_BITS-1:0] rand_word(input int density);
		logic [csse_pkg::SET_WORD_BITS-1:0] w;
		w = {$urandom, $urandom};
		case (density)
			0: w = w & {$urandom, $urandom};
			2: w = w | {$urandom, $urandom};
			default: ;
		endcase
		return w;
	endfunction

	initial begin
		logic [csse_pkg::MODE_BITS-1:0]     md;
		logic [csse_pkg::SET_WORD_BITS-1:0] w [csse_pkg::SET_WORDS];
		logic                               an;
		logic                               fr;
		logic                               ex;
		int                                 dens;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed part: low quarter and byte 255 are members, span mode
		program_regs('1, '0, '0, 64'h8000_0000_0000_0000, csse_pkg::MODE_SPAN,
			1'b0, 1'b0, 1'b1);
		queue_load(8'h00, 8'hFF);
		queue_load(8'hFF, 8'h00);
		queue_load(8'h41, 8'h61);
		queue_load(8'h61, 8'h41);
		queue_load(8'h80, 8'h7F);
		queue_load(8'h7F, 8'h80);
		// unused command and a byte with no scan open are both ignored
		beats_pending.push_back(fresh_beat(CMD_SPARE));
		queue_char(8'h00, 1'b0);
		// begin with nothing left fails at once
		queue_begin(16'h1234, 1'b1);
		// cursor wraps past the top
		queue_begin(16'hFFFE, 1'b0);
		queue_char(8'h00, 1'b0);
		queue_char(8'hFF, 1'b0);
		queue_char(8'h00, 1'b1);
		// first byte not a member
		queue_begin(16'h0000, 1'b0);
		queue_char(8'h41, 1'b0);
		// begin during an open scan abandons it
		queue_begin(16'hFFFF, 1'b0);
		queue_char(8'h00, 1'b0);
		queue_begin(16'h0005, 1'b0);
		queue_char(8'h00, 1'b0);
		queue_char(8'h80, 1'b0);
		// late byte after the verdict is ignored
		queue_char(8'h7F, 1'b1);
		queue_begin(16'h8000, 1'b0);
		queue_char(8'hFF, 1'b1);
		drain(SETTLE);

		// random part: one setting per phase, two chunks with a full pause between
		for (int k = 0; k < PHASES; k++) begin
			case (k)
				0: md = csse_pkg::MODE_SPAN;
				1: md = csse_pkg::MODE_BREAK;
				2: md = csse_pkg::MODE_BREAK_PAST;
				3: md = csse_pkg::MODE_PAST_NON;
				4: md = csse_pkg::MODE_FIND_MEM;
				5: md = csse_pkg::MODE_FIND_NON;
				6: md = csse_pkg::MODE_FIND_MEM;
				7: md = csse_pkg::MODE_FIND_NON;
				8: md = csse_pkg::MODE_SPAN;
				9: md = MODE_SPARE_LO;
				10: md = MODE_SPARE_HI;
				default: md = 3'($urandom_range(5));
			endcase
			dens = $urandom_range(2);
			foreach (w[i]) w[i] = rand_word(dens);
			if (k == 1 || k == 7) foreach (w[i]) w[i] = '1;
			if (k == 2 || k == 6) foreach (w[i]) w[i] = '0;
			an = ($urandom_range(2) == 0);
			fr = 1'($urandom);
			ex = 1'($urandom);
			if (k == 4) begin an = 1'b1; fr = 1'b1; ex = 1'b0; end
			if (k == 5) begin an = 1'b0; fr = 1'b0; ex = 1'b0; end
			if (k == 11) begin an = 1'b0; fr = 1'b1; ex = 1'b1; end
			program_regs(w[0], w[1], w[2], w[3], md, an, fr, ex);

			calm = (k == 6);
			for (int i = 0; i < 8; i++)
				queue_load(csse_pkg::BYTE_BITS'($urandom), csse_pkg::BYTE_BITS'($urandom));
			if (k == 3 || k == 8) burst_ask++;
			queue_scan_traffic(CHUNK_ITEMS);
			drain(0);
			queue_scan_traffic(CHUNK_ITEMS);
			drain(SETTLE);
		end
		calm = 1'b0;
		drain(SETTLE * 2);

		if (verdicts_due.size() != 0)
			flag_error($sformatf("%0d verdicts never came", verdicts_due.size()));
		$display("run covered %0d beats, %0d verdicts and %0d register writes over %0d settings",
			beats_taken, verdicts_seen, regs_written, settings_done);
		$display("all six scan modes, unused modes, fold loads, cursor wrap; %0d mismatches",
			errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
